FILE: rtl/core/compass_heading_filter_core_macros.svh
`ifndef COMPASS_HEADING_FILTER_CORE_MACROS_SVH
`define COMPASS_HEADING_FILTER_CORE_MACROS_SVH
// implication check, registered next cycle
`define CHF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
// same-cycle implication
`define CHF_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`endif

FILE: rtl/core/chf_pkg.sv
package chf_pkg;
  localparam int AtanLen = 24;
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] REG_READY    = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_ALPHA    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               read_ok;
  } in_word_t;

  typedef struct packed {
    logic [15:0] heading;
    logic        heading_valid;
    logic        updated;
    logic        calibrating;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_word_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage

FILE: rtl/core/chf_stream_if.sv
interface chf_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/chf_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle. Inputs are scaled by 2^16
// before the iterations and the shifts are arithmetic, so every shift floors.
module chf_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [17:0] x_in,
  input  logic signed [17:0] y_in,
  output logic               done,
  output logic [15:0]        angle
);
  import chf_pkg::*;
  localparam int N = (STEPS > AtanLen) ? AtanLen : STEPS;
  localparam int XW = 18 + 16 + 2;

  logic signed [XW-1:0] cx, cy;
  logic [31:0] z;
  logic [4:0] i;
  logic busy;
  logic signed [XW-1:0] dx, dy;

  assign dx = cy >>> i;
  assign dy = cx >>> i;
  assign angle = 16'((z + 32'h8000) >> 16);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      i <= '0;
      if (x_in == 0 || y_in == 0) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (y_in == 0)
          z <= (x_in < 0) ? 32'h80000000 : 32'h0;
        else
          z <= (y_in > 0) ? 32'h40000000 : 32'hC0000000;
      end else begin
        busy <= 1'b1;
        if (x_in < 0) begin
          cx <= -({{(XW-18){x_in[17]}}, x_in} <<< 16);
          cy <= -({{(XW-18){y_in[17]}}, y_in} <<< 16);
          z  <= 32'h80000000;
        end else begin
          cx <= {{(XW-18){x_in[17]}}, x_in} <<< 16;
          cy <= {{(XW-18){y_in[17]}}, y_in} <<< 16;
          z  <= 32'h0;
        end
      end
    end else if (busy) begin
      if (!cy[XW-1]) begin
        cx <= cx + dx; cy <= cy - dy; z <= z + atan_entry(i);
      end else begin
        cx <= cx - dx; cy <= cy + dy; z <= z - atan_entry(i);
      end
      i <= i + 5'd1;
      if (32'(i) == N - 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

FILE: rtl/core/compass_heading_filter_core.sv
// Compass heading filter. One input word gives one output word. Commands,
// ignored samples and failed reads go from S_DECIDE straight to S_OUT; a kept
// sample runs the CORDIC (steps capped at 24; a centered vector on an axis or
// at zero skips the micro-rotations), one CORDIC micro-rotation per cycle, then
// a bit-serial shift-add multiply of the angle error by alpha.
// Config writes are accepted at any time and must be made while idle.
module compass_heading_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst,
  chf_stream_if.sink   in_ch,
  chf_stream_if.source out_ch,
  chf_stream_if.sink   cfg_ch
);
  import chf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DECIDE = 6'b000010, S_CORDIC = 6'b000100,
    S_MUL = 6'b001000, S_ADD = 6'b010000, S_OUT = 6'b100000
  } state_t;
  state_t state;

  in_word_t  iw;
  out_word_t ow;
  cfg_word_t cw;
  assign iw = in_word_t'(in_ch.data);
  assign cw = cfg_word_t'(cfg_ch.data);
  assign out_ch.data = $bits(out_ch.data)'(ow);

  logic sensor_ready;
  logic [15:0] update_interval_ms, filter_alpha;
  logic [31:0] last_accept_ms, filtered_angle;
  logic cal_active, read_good;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  in_word_t cur;
  logic upd;

  logic c_start, c_done;
  logic signed [17:0] cxv, cyv;
  logic [15:0] c_angle;
  logic signed [15:0] nminx, nmaxx, nminy, nmaxy;

  logic signed [48:0] acc;
  logic signed [32:0] delta;
  logic [15:0] mul_a;
  logic [4:0] mcnt;

  chf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .x_in(cxv), .y_in(cyv),
    .done(c_done), .angle(c_angle)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);

  always_comb begin
    nminx = min_x; nmaxx = max_x; nminy = min_y; nmaxy = max_y;
    if (cal_active) begin
      if (cur.raw_x < min_x) nminx = cur.raw_x;
      if (cur.raw_x > max_x) nmaxx = cur.raw_x;
      if (cur.raw_y < min_y) nminy = cur.raw_y;
      if (cur.raw_y > max_y) nmaxy = cur.raw_y;
    end
    cxv = 18'(2 * 18'(cur.raw_x)) - (18'(nmaxx) + 18'(nminx));
    cyv = 18'(2 * 18'(cur.raw_y)) - (18'(nmaxy) + 18'(nminy));
  end

  always_ff @(posedge clk) begin
    c_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      sensor_ready <= 1'b0;
      update_interval_ms <= 16'd100;
      filter_alpha <= 16'd9830;
      last_accept_ms <= '0;
      cal_active <= 1'b0;
      min_x <= 16'sd32767; max_x <= -16'sd32768;
      min_y <= 16'sd32767; max_y <= -16'sd32768;
      filtered_angle <= '0;
      read_good <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cw.index)
          REG_READY:    sensor_ready <= cw.data[0];
          REG_INTERVAL: update_interval_ms <= cw.data;
          REG_ALPHA:    filter_alpha <= cw.data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cur <= iw;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          upd <= 1'b0;
          state <= S_OUT;
          unique case (cur.kind)
            KIND_SAMPLE:
              if (sensor_ready &&
                  (cur.now_ms - last_accept_ms) >= {16'd0, update_interval_ms}) begin
                last_accept_ms <= cur.now_ms;
                read_good <= cur.read_ok;
                if (cur.read_ok) begin
                  min_x <= nminx; max_x <= nmaxx; min_y <= nminy; max_y <= nmaxy;
                  c_start <= 1'b1;
                  upd <= 1'b1;
                  state <= S_CORDIC;
                end
              end
            KIND_START: begin
              cal_active <= 1'b1;
              min_x <= 16'sd32767; max_x <= -16'sd32768;
              min_y <= 16'sd32767; max_y <= -16'sd32768;
            end
            KIND_FINISH: cal_active <= 1'b0;
            default: ;
          endcase
        end
        S_CORDIC: if (c_done) begin
          delta <= 33'(signed'({c_angle, 16'd0} - filtered_angle));
          mul_a <= filter_alpha;
          acc <= 49'sd32768;
          mcnt <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_a[0]) acc <= acc + (49'(delta) <<< mcnt);
          mul_a <= mul_a >> 1;
          mcnt <= mcnt + 5'd1;
          if (mcnt == 5'd15) state <= S_ADD;
        end
        S_ADD: begin
          filtered_angle <= filtered_angle + 32'(acc >>> 16);
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ow.heading = 16'((filtered_angle + 32'h8000) >> 16);
  assign ow.heading_valid = sensor_ready & read_good;
  assign ow.updated = upd;
  assign ow.calibrating = cal_active;
endmodule

FILE: rtl/core/chf_checker.sv
`include "compass_heading_filter_core_macros.svh"
module chf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [18:0] out_data
);
  `CHF_ASSERT_NOW(a_no_overlap, clk, rst, out_valid, !in_ready)
  `CHF_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHF_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `CHF_ASSERT_NOW(a_upd_valid, clk, rst, out_valid && out_data[1], out_data[2])
endmodule

bind compass_heading_filter_core chf_checker u_chf_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

FILE: sim/chf_heading_checker.sv
`timescale 1ns / 100ps

module chf_heading_checker
  import chf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst,
  chf_stream_if  in_ch,
  chf_stream_if  out_ch,
  chf_stream_if  cfg_ch,
  output int     pending,
  output int     fail_count
);

  logic        sensor_ready;
  logic [15:0] interval_ms;
  logic [15:0] alpha;
  logic [31:0] last_ms;
  logic        cal_on;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  logic [31:0] filt_angle;
  logic        read_good;

  out_word_t heading_q[$];

  function automatic logic [15:0] atan2_bam(input int x, input int y);
    longint cx, cy, dx, dy;
    logic [31:0] z;
    int steps;
    z = 32'h0;
    steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
    if (x == 0 && y == 0) return 16'h0000;
    if (y == 0) return (x > 0) ? 16'h0000 : 16'h8000;
    if (x == 0) return (y > 0) ? 16'h4000 : 16'hC000;
    cx = longint'(x) * 65536;
    cy = longint'(y) * 65536;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z = 32'h80000000;
    end
    for (int i = 0; i < steps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        z += atan_entry(5'(i));
      end else begin
        cx -= dx;
        cy += dy;
        z -= atan_entry(5'(i));
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  task automatic clear_extremes();
    min_x = 16'sh7FFF;
    max_x = -16'sh8000;
    min_y = 16'sh7FFF;
    max_y = -16'sh8000;
  endtask

  task automatic predict(input in_word_t w);
    out_word_t e;
    logic [31:0] du, target, rounded;
    longint d, stepv;
    int cxv, cyv;
    logic upd;
    upd = 1'b0;
    case (w.kind)
      KIND_SAMPLE: begin
        if (sensor_ready && (w.now_ms - last_ms) >= {16'h0, interval_ms}) begin
          last_ms = w.now_ms;
          read_good = w.read_ok;
          if (w.read_ok) begin
            if (cal_on) begin
              if (w.raw_x < min_x) min_x = w.raw_x;
              if (w.raw_x > max_x) max_x = w.raw_x;
              if (w.raw_y < min_y) min_y = w.raw_y;
              if (w.raw_y > max_y) max_y = w.raw_y;
            end
            cxv = 2 * int'(w.raw_x) - (int'(max_x) + int'(min_x));
            cyv = 2 * int'(w.raw_y) - (int'(max_y) + int'(min_y));
            target = {atan2_bam(cxv, cyv), 16'h0};
            du = target - filt_angle;
            d = longint'(signed'(du));
            stepv = (d * longint'(alpha) + 32768) >>> 16;
            filt_angle = filt_angle + stepv[31:0];
            upd = 1'b1;
          end
        end
      end
      KIND_START: begin
        cal_on = 1'b1;
        clear_extremes();
      end
      KIND_FINISH: cal_on = 1'b0;
      default: ;
    endcase
    rounded = filt_angle + 32'h8000;
    e.heading = rounded[31:16];
    e.heading_valid = sensor_ready & read_good;
    e.updated = upd;
    e.calibrating = cal_on;
    heading_q.push_back(e);
  endtask

  always @(posedge clk) begin
    cfg_word_t c;
    out_word_t got, want;
    if (rst) begin
      sensor_ready = 1'b0;
      interval_ms = 16'd100;
      alpha = 16'd9830;
      last_ms = 32'h0;
      cal_on = 1'b0;
      clear_extremes();
      filt_angle = 32'h0;
      read_good = 1'b0;
      heading_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        c = cfg_ch.data;
        case (c.index)
          REG_READY: sensor_ready = c.data[0];
          REG_INTERVAL: interval_ms = c.data;
          REG_ALPHA: alpha = c.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (heading_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected word %h", got);
        end else begin
          want = heading_q.pop_front();
          if (got.heading !== want.heading || got.heading_valid !== want.heading_valid ||
              got.updated !== want.updated || got.calibrating !== want.calibrating) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: heading %h/%h valid %b/%b updated %b/%b cal %b/%b (exp/act)",
                       want.heading, got.heading, want.heading_valid, got.heading_valid,
                       want.updated, got.updated, want.calibrating, got.calibrating);
          end
        end
      end
    end
    pending = heading_q.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import chf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   pending;
  int   fail_count;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic [31:0] now_ms = 32'h0;

  chf_stream_if #(.W($bits(in_word_t)))  in_ch();
  chf_stream_if #(.W($bits(out_word_t))) out_ch();
  chf_stream_if #(.W($bits(cfg_word_t))) cfg_ch();

  compass_heading_filter_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  chf_heading_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .pending(pending), .fail_count(fail_count)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // output side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if ($urandom_range(0, 2) != 0) begin
          out_ch.ready <= 1'b0;
          repeat (rand_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [31:0] t,
                           input logic [15:0] x, input logic [15:0] y, input logic ok,
                           input bit gaps);
    in_word_t w;
    logic rdy;
    int g;
    w.kind = kind;
    w.now_ms = t;
    w.raw_x = x;
    w.raw_y = y;
    w.read_ok = ok;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_word_t c;
    logic rdy;
    c.index = idx;
    c.data = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do begin
      @(negedge clk);
      rdy = cfg_ch.ready;
      @(posedge clk);
    end while (!rdy);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic sample(input logic [15:0] x, input logic [15:0] y, input logic [31:0] dt,
                        input logic ok);
    now_ms = now_ms + dt;
    send_word(KIND_SAMPLE, now_ms, x, y, ok, 1'b1);
  endtask

  task automatic random_word(input int interval);
    int r;
    logic [31:0] dt;
    r = $urandom_range(0, 99);
    if (r < 6)
      send_word(KIND_START, $urandom, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    else if (r < 11)
      send_word(KIND_FINISH, $urandom, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    else if (r < 13)
      send_word(2'd3, $urandom, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    else begin
      r = $urandom_range(0, 19);
      if (r == 0) dt = $urandom;
      else if (r < 4) dt = $urandom_range(0, interval);
      else dt = 32'(interval + $urandom_range(0, 300));
      sample(16'($urandom), 16'($urandom), dt, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    int interval;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // not ready: samples ignored, commands still work
    sample(16'h1234, 16'h4321, 32'd500, 1'b1);
    send_word(KIND_START, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    send_word(KIND_FINISH, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    drain();
    cfg_write(REG_READY, 16'h1);
    cfg_write(REG_INTERVAL, 16'h0);
    cfg_write(REG_ALPHA, 16'hFFFF);

    // zero vector, then exact half-turn tie
    send_word(KIND_START, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    sample(16'd100, 16'd0, 32'd0, 1'b1);
    sample(-16'sd100, 16'd0, 32'd0, 1'b1);
    sample(16'd0, 16'd50, 32'd1, 1'b1);
    sample(16'd0, -16'sd50, 32'd1, 1'b1);
    send_word(KIND_FINISH, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    // no calibration data extremes
    send_word(KIND_START, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    send_word(KIND_FINISH, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    sample(16'h7FFF, 16'h7FFF, 32'd5, 1'b1);
    sample(16'h8000, 16'h8000, 32'd5, 1'b1);
    sample(16'h7FFF, 16'h8000, 32'd5, 1'b1);
    sample(16'h8000, 16'h7FFF, 32'd5, 1'b1);
    sample(16'hFFFF, 16'h0001, 32'd5, 1'b0);
    sample(16'h0001, 16'hFFFF, 32'd5, 1'b1);
    send_word(2'd3, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    drain();
    cfg_write(REG_INTERVAL, 16'hFFFF);
    cfg_write(REG_ALPHA, 16'h0);
    sample(16'd10, 16'd10, 32'd100, 1'b1);
    sample(16'd10, 16'd10, 32'd65535, 1'b1);
    sample(16'd10, 16'd10, 32'hFFFF0000, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: interval = 100;
        1: interval = 0;
        2: interval = 65535;
        default: interval = $urandom_range(0, 400);
      endcase
      cfg_write(REG_READY, (ph == 4) ? 16'h0 : 16'h1);
      cfg_write(REG_INTERVAL, 16'(interval));
      cfg_write(REG_ALPHA, (ph == 1) ? 16'hFFFF : (ph == 0) ? 16'd9830 : 16'($urandom));
      if (ph == 2) begin
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) random_word(interval);
      end
      for (int i = 0; i < 100; i++) begin
        random_word(interval);
        if (ph == 3 && i == 50) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: compass_heading_filter_core.f
+incdir+rtl/core
rtl/core/chf_pkg.sv
rtl/core/chf_stream_if.sv
rtl/core/chf_cordic.sv
rtl/core/compass_heading_filter_core.sv
rtl/core/chf_checker.sv
sim/chf_heading_checker.sv
sim/tb.sv
